### rtl/mafir_pkg.sv
// Shared types and constants for the moving average / lowpass FIR block.
// Holds the sample and coefficient types, coefficient reset values, FSM states
// and the status structs passed from the datapath units to the top level.
package mafir_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 16;
   localparam int COEF_REGS  = 6;
   localparam int COEF_IDX_W = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int FRAC_W     = 16;

   // Highest coefficient register index; also selects the weight for every inner tap
   // at least COEF_LAST taps from either end of a long filter.
   localparam logic [COEF_IDX_W-1:0] COEF_LAST = COEF_IDX_W'(COEF_REGS - 1);

   typedef logic [COEF_W-1:0]            coef_type;
   typedef coef_type [COEF_REGS-1:0]     coef_bank_type;
   typedef logic signed [SAMPLE_W-1:0]   sample_type;

   localparam coef_bank_type COEF_RESET = {
      16'd10689, 16'd9162, 16'd6593, 16'd3795, 16'd1665, 16'd865
   };

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic       done;
      sample_type mean;
   } avg_status_type;

   typedef struct packed {
      logic       done;
      sample_type lowpass;
      logic       clipped;
   } fir_status_type;

endpackage

### rtl/mafir_if.sv
// Valid/ready channel interfaces for the input sample word and the result word.
// Depends on mafir_pkg for the sample type.
interface mafir_req_if;
   import mafir_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface mafir_rsp_if;
   import mafir_pkg::*;

   logic       valid;
   logic       ready;
   sample_type window_mean;
   sample_type lowpass_out;
   logic       lowpass_clipped;

   modport source (output valid, output window_mean, output lowpass_out,
                   output lowpass_clipped, input ready);
   modport sink   (input valid, input window_mean, input lowpass_out,
                   input lowpass_clipped, output ready);
endinterface

### rtl/mafir_avg.sv
// Moving average unit: circular window memory with a running sum, then a
// reciprocal multiply with one correction step for the divide by AVG_LEN.
// Depends on mafir_pkg.
module mafir_avg #(
   parameter int AVG_LEN = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  mafir_pkg::sample_type      word_in,
   output mafir_pkg::avg_status_type  status
);
   import mafir_pkg::*;

   localparam int SLOT_W = $clog2(AVG_LEN);
   localparam int SUM_W  = SAMPLE_W + $clog2(AVG_LEN);
   localparam int MAG_W  = SUM_W;
   localparam logic [MAG_W-1:0]        RECIP     = MAG_W'((1 << MAG_W) / AVG_LEN);
   localparam logic [MAG_W-1:0]        DIVISOR   = MAG_W'(AVG_LEN);
   localparam logic [SLOT_W-1:0]       SLOT_LAST = SLOT_W'(AVG_LEN - 1);
   localparam logic signed [SUM_W-1:0] SUM_MAX   =
      SUM_W'(AVG_LEN * ((1 << (SAMPLE_W - 1)) - 1));
   localparam logic signed [SUM_W-1:0] SUM_MIN   =
      SUM_W'(-(AVG_LEN * (1 << (SAMPLE_W - 1))));

   sample_type                win_mem [AVG_LEN];
   logic [AVG_LEN-1:0]        win_vld_ff;
   logic [SLOT_W-1:0]         slot_ff;
   logic [SLOT_W-1:0]         slot_in;
   logic [2:0]                st_ff;
   sample_type                rd_ff;
   logic                      rd_vld_ff;
   sample_type                word_ff;
   sample_type                old_val;
   logic signed [SUM_W-1:0]   sum_ff;
   logic signed [SUM_W-1:0]   sum_in;
   logic [MAG_W-1:0]          mag_ff;
   logic [MAG_W-1:0]          mag_in;
   logic                      sign_ff;
   logic [2*MAG_W-1:0]        prod_ff;
   logic [MAG_W-1:0]          q_est;
   logic [MAG_W-1:0]          rem;
   logic [MAG_W-1:0]          q_fix;
   sample_type                mean_ff;
   sample_type                mean_in;
   logic                      done_ff;

   always_comb begin
      old_val = rd_vld_ff ? rd_ff : '0;
      sum_in  = sum_ff + SUM_W'(word_ff) - SUM_W'(old_val);
      slot_in = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
      mag_in  = sum_ff[SUM_W-1] ? MAG_W'(-sum_ff) : MAG_W'(sum_ff);
      // Quotient estimate is exact or one low; fix it from the remainder.
      q_est   = prod_ff[2*MAG_W-1:MAG_W];
      rem     = mag_ff - q_est * DIVISOR;
      q_fix   = (rem >= DIVISOR) ? q_est + 1'b1 : q_est;
      mean_in = sign_ff ? SAMPLE_W'(-q_fix) : SAMPLE_W'(q_fix);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= '0;
         win_vld_ff <= '0;
         slot_ff    <= '0;
         sum_ff     <= '0;
         done_ff    <= 1'b0;
      end else begin
         st_ff <= {st_ff[1:0], start};
         if (st_ff[0]) begin
            win_vld_ff[slot_ff] <= 1'b1;
            slot_ff             <= slot_in;
            sum_ff              <= sum_in;
         end
         if (start) begin
            done_ff <= 1'b0;
         end else if (st_ff[2]) begin
            done_ff <= 1'b1;
         end
      end
   end

   // Read the outgoing word on start, write the new word back in the following cycle.
   always_ff @(posedge clock) begin
      if (st_ff[0]) begin
         win_mem[slot_ff] <= word_ff;
      end
      if (start) begin
         rd_ff     <= win_mem[slot_ff];
         rd_vld_ff <= win_vld_ff[slot_ff];
         word_ff   <= word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (st_ff[1]) begin
         mag_ff  <= mag_in;
         sign_ff <= sum_ff[SUM_W-1];
         prod_ff <= mag_in * RECIP;
      end
      if (st_ff[2]) begin
         mean_ff <= mean_in;
      end
   end

   assign status.done = done_ff;
   assign status.mean = mean_ff;

   a_start_empty: assert property (@(posedge clock) disable iff (reset)
      start |-> st_ff == '0)
      else $error("avg: new word started while the previous one is in flight");

   a_one_word: assert property (@(posedge clock) disable iff (reset)
      $onehot0(st_ff))
      else $error("avg: more than one word in the pipeline");

   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      sum_ff <= SUM_MAX && sum_ff >= SUM_MIN)
      else $error("avg: running sum outside the window range");

endmodule

### rtl/mafir_fir.sv
// Lowpass FIR unit: circular delay-line memory swept oldest to newest through
// one shared multiply-accumulate, then truncation toward zero and saturation.
// Depends on mafir_pkg.
module mafir_fir #(
   parameter int TAP_COUNT = 12
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  mafir_pkg::sample_type      word_in,
   input  mafir_pkg::coef_bank_type   coef,
   output mafir_pkg::fir_status_type  status
);
   import mafir_pkg::*;

   localparam int TW     = $clog2(TAP_COUNT);
   localparam int PROD_W = SAMPLE_W + COEF_W + 1;
   localparam int ACC_W  = PROD_W + $clog2(TAP_COUNT);
   localparam int Q_W    = ACC_W - FRAC_W;
   localparam int KW     = (TW > COEF_IDX_W) ? TW : COEF_IDX_W;
   localparam logic [TW-1:0]         TAP_LAST = TW'(TAP_COUNT - 1);
   localparam sample_type            RAIL_HI  = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam sample_type            RAIL_LO  = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic signed [Q_W-1:0] OUT_MAX  = Q_W'(RAIL_HI);
   localparam logic signed [Q_W-1:0] OUT_MIN  = Q_W'(RAIL_LO);

   sample_type                tap_mem [TAP_COUNT];
   logic [TAP_COUNT-1:0]      tap_vld_ff;
   logic [TW-1:0]             slot_ff;
   logic [TW-1:0]             slot_next;
   logic [TW-1:0]             rd_addr;
   logic [TW-1:0]             rd_ptr_ff;
   logic [TW-1:0]             rd_ptr_next;
   logic [TW-1:0]             cnt_addr;
   logic [TW-1:0]             cnt_ff;
   logic [TW-1:0]             mirror;
   logic [KW-1:0]             k_raw;
   logic [COEF_IDX_W-1:0]     coef_sel;
   logic                      issue;
   logic                      iss_ff;
   logic                      p1_ff;
   logic                      p1_last_ff;
   logic                      p2_ff;
   logic                      p2_last_ff;
   logic                      fin_ff;
   logic                      done_ff;
   sample_type                rd_ff;
   logic                      rd_vld_ff;
   sample_type                tap_val;
   coef_type                  coef_rd_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   acc_in;
   logic signed [Q_W-1:0]     q_val;
   sample_type                out_ff;
   sample_type                out_in;
   logic                      clip_ff;
   logic                      clip_in;

   always_comb begin
      slot_next   = (slot_ff == TAP_LAST) ? '0 : slot_ff + 1'b1;
      issue       = start || iss_ff;
      // The sweep starts at the oldest entry, right after the one being written.
      rd_addr     = start ? slot_next : rd_ptr_ff;
      rd_ptr_next = (rd_addr == TAP_LAST) ? '0 : rd_addr + 1'b1;
      cnt_addr    = start ? '0 : cnt_ff;
      mirror      = TAP_LAST - cnt_addr;
      k_raw       = (cnt_addr < mirror) ? KW'(cnt_addr) : KW'(mirror);
      coef_sel    = (k_raw > KW'(COEF_LAST)) ? COEF_LAST : COEF_IDX_W'(k_raw);
      tap_val     = rd_vld_ff ? rd_ff : '0;
      acc_in      = acc_ff + ACC_W'(prod_ff);
   end

   always_comb begin
      q_val = acc_ff[ACC_W-1:FRAC_W];
      // Round a negative sum with a nonzero fraction up, toward zero.
      if (acc_ff[ACC_W-1] && (acc_ff[FRAC_W-1:0] != '0)) begin
         q_val = q_val + 1'b1;
      end
      if (q_val > OUT_MAX) begin
         out_in  = RAIL_HI;
         clip_in = 1'b1;
      end else if (q_val < OUT_MIN) begin
         out_in  = RAIL_LO;
         clip_in = 1'b1;
      end else begin
         out_in  = SAMPLE_W'(q_val);
         clip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_vld_ff <= '0;
         slot_ff    <= '0;
         iss_ff     <= 1'b0;
         p1_ff      <= 1'b0;
         p1_last_ff <= 1'b0;
         p2_ff      <= 1'b0;
         p2_last_ff <= 1'b0;
         fin_ff     <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         if (start) begin
            tap_vld_ff[slot_ff] <= 1'b1;
            slot_ff             <= slot_next;
         end
         iss_ff     <= issue && (cnt_addr != TAP_LAST);
         p1_ff      <= issue;
         p1_last_ff <= issue && (cnt_addr == TAP_LAST);
         p2_ff      <= p1_ff;
         p2_last_ff <= p1_last_ff;
         fin_ff     <= p2_last_ff;
         if (start) begin
            done_ff <= 1'b0;
         end else if (fin_ff) begin
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         tap_mem[slot_ff] <= word_in;
      end
      if (issue) begin
         rd_ff      <= tap_mem[rd_addr];
         rd_vld_ff  <= tap_vld_ff[rd_addr];
         coef_rd_ff <= coef[coef_sel];
         rd_ptr_ff  <= rd_ptr_next;
         cnt_ff     <= cnt_addr + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (p1_ff) begin
         prod_ff <= tap_val * $signed({1'b0, coef_rd_ff});
      end
      if (start) begin
         acc_ff <= '0;
      end else if (p2_ff) begin
         acc_ff <= acc_in;
      end
      if (fin_ff) begin
         out_ff  <= out_in;
         clip_ff <= clip_in;
      end
   end

   assign status.done    = done_ff;
   assign status.lowpass = out_ff;
   assign status.clipped = clip_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !iss_ff && !p1_ff && !p2_ff && !fin_ff)
      else $error("fir: new word started while the sweep is running");

   a_drained: assert property (@(posedge clock) disable iff (reset)
      fin_ff |-> !iss_ff && !p1_ff && !p2_ff)
      else $error("fir: finalize with products still in flight");

   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      fin_ff |=> !clip_ff || out_ff == RAIL_HI || out_ff == RAIL_LO)
      else $error("fir: clip flag set on a value off the rails");

endmodule

### rtl/moving_average_and_fir_lowpass.sv
// One input word is in work at a time: a new word is accepted only once the result of
// the last one has moved to the output register. The FIR delay-line memory feeds one
// shared multiplier one tap per cycle, which sets the word rate.
// Reset (synchronous): window and delay-line valid bits, running sum and result valid
// clear at once, coefficients return to their defaults; no clearing pass is needed.
module moving_average_and_fir_lowpass #(
   parameter int AVG_LEN   = 5,
   parameter int TAP_COUNT = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   mafir_req_if.sink                           req_bus,
   mafir_rsp_if.source                         rsp_bus,
   input  logic                                csr_we,
   input  logic [mafir_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mafir_pkg::COEF_W-1:0]        csr_wdata
);
   import mafir_pkg::*;

   state_type       state_ff;
   state_type       state_in;
   coef_bank_type   coef_ff;
   logic            req_ready;
   logic            accept;
   logic            rsp_load;
   logic            rsp_valid_ff;
   sample_type      mean_ff;
   sample_type      lowpass_ff;
   logic            clipped_ff;
   avg_status_type  avg_st;
   fir_status_type  fir_st;

   mafir_avg #(
      .AVG_LEN (AVG_LEN)
   ) u_avg (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .word_in (req_bus.sample_in),
      .status  (avg_st)
   );

   mafir_fir #(
      .TAP_COUNT (TAP_COUNT)
   ) u_fir (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .word_in (req_bus.sample_in),
      .coef    (coef_ff),
      .status  (fir_st)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_RUN: begin
            // Hand over once both units finish and the output register is free.
            rsp_load = avg_st.done && fir_st.done && (!rsp_valid_ff || rsp_bus.ready);
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign accept        = req_bus.valid && req_ready;
   assign req_bus.ready = req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         coef_ff      <= COEF_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we && (csr_index <= COEF_LAST)) begin
            coef_ff[csr_index] <= csr_wdata;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         mean_ff    <= avg_st.mean;
         lowpass_ff <= fir_st.lowpass;
         clipped_ff <= fir_st.clipped;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.window_mean     = mean_ff;
   assign rsp_bus.lowpass_out     = lowpass_ff;
   assign rsp_bus.lowpass_clipped = clipped_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_bus.ready)
      else $error("top: ready stayed high after a word was accepted");

   a_load_from_run: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RUN))
      else $error("top: result loaded with no word in work");

   a_units_agree: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> avg_st.done == fir_st.done)
      else $error("top: average and filter units out of step");

endmodule
